[src/silence_timeout_frame_receiver_unit_assert.svh]
// Assertion macros for the checker file of the frame receiver.
// Each macro needs clk and rst_n in scope.
`ifndef SILENCE_TIMEOUT_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SILENCE_TIMEOUT_FRAME_RECEIVER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STFR_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STFR_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/stfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package stfr_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = 6;
    localparam int CNT_W     = 7;
    localparam int TICKS_W   = 16;

    localparam logic [TICKS_W-1:0] SILENCE_RESET = 16'hE000;

    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] read_index;
        logic [7:0]        rx_byte;
        logic [1:0]        mode;
    } item_t;

    typedef struct packed {
        logic             byte_dropped;
        logic             timer_running;
        logic [7:0]       read_data;
        logic [CNT_W-1:0] byte_count;
        logic             frame_ready;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_W    = 24;
    localparam int IN_W     = 16;

endpackage

`default_nettype wire

[src/stfr_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module stfr_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire stfr_pkg::item_t               in_item,
    input  wire logic [stfr_pkg::TICKS_W-1:0]  silence_ticks,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output stfr_pkg::result_t                  res
);
    import stfr_pkg::*;

    logic [7:0]         mem [BUF_DEPTH];
    logic [7:0]         mem_q_reg;

    logic [CNT_W-1:0]   held_reg, held_next;
    logic [TICKS_W-1:0] silence_reg, silence_next;
    logic               counting_reg, counting_next;
    logic               ready_reg, ready_next;

    logic               s1_valid_reg;
    result_t            s1_res_reg;
    logic               s1_hit_reg;

    logic               accept;
    logic               wr_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_hit;
    logic               dropped;

    assign in_ready = !s1_valid_reg || res_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        held_next     = held_reg;
        silence_next  = silence_reg;
        counting_next = counting_reg;
        ready_next    = ready_reg;
        wr_en         = 1'b0;
        rd_addr       = in_item.read_index;
        rd_hit        = 1'b0;
        dropped       = 1'b0;
        case (in_item.mode)
            MODE_BYTE:
            begin
                if (held_reg < CNT_W'(BUF_DEPTH))
                begin
                    wr_en     = 1'b1;
                    held_next = held_reg + 1'b1;
                end
                else
                begin
                    dropped = 1'b1;
                end
                silence_next  = '0;
                counting_next = 1'b1;
            end
            MODE_TICK:
            begin
                if (counting_reg)
                begin
                    silence_next = silence_reg + 1'b1;
                    if (silence_next >= silence_ticks)
                    begin
                        counting_next = 1'b0;
                        if (held_reg != '0)
                        begin
                            ready_next = 1'b1;
                        end
                    end
                end
            end
            MODE_READ:
            begin
                rd_hit = {1'b0, in_item.read_index} < held_reg;
            end
            default:
            begin
                rd_addr    = '0;
                rd_hit     = held_reg != '0;
                held_next  = '0;
                ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            silence_reg  <= '0;
            counting_reg <= 1'b0;
            ready_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_reg     <= held_next;
                silence_reg  <= silence_next;
                counting_reg <= counting_next;
                ready_reg    <= ready_next;
                s1_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg.frame_ready   <= ready_next;
            s1_res_reg.byte_count    <= held_next;
            s1_res_reg.read_data     <= '0;
            s1_res_reg.timer_running <= counting_next;
            s1_res_reg.byte_dropped  <= dropped;
            s1_hit_reg               <= rd_hit;
            mem_q_reg                <= mem[rd_addr];
            if (wr_en)
            begin
                mem[held_reg[ADDR_W-1:0]] <= in_item.rx_byte;
            end
        end
    end

    always_comb
    begin
        res           = s1_res_reg;
        res.read_data = s1_hit_reg ? mem_q_reg : 8'h00;
    end

    assign res_valid = s1_valid_reg;

endmodule

`default_nettype wire

[src/silence_timeout_frame_receiver_unit.sv]
`timescale 1ns / 1ps
// Channel   Direction  Content
// s_*       in         tuser = mode; tdata = rx_byte, read_index
// m_*       out        tdata = frame_ready, byte_count, read_data, timer_running,
//                      byte_dropped
// cfg_*     in         silence_ticks write, no read-back
//
// One item is taken per cycle while s_tready is high. A result is registered
// first in the state update and frame store read stage, then in the output
// register. s_tready drops only when both the stage behind the frame
// store and the output register hold results and m_tready is low. Reset clears
// the counters and flags at once; the frame store is not cleared.
`default_nettype none

module silence_timeout_frame_receiver_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [7:0] rx_byte, [13:8] read_index, [15:14] zero
    input  wire logic [stfr_pkg::IN_W-1:0]     s_tdata,
    // [1:0] mode
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] frame_ready, [7:1] byte_count, [15:8] read_data, [16] timer_running,
    // [17] byte_dropped, [23:18] zero
    output logic [stfr_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [stfr_pkg::TICKS_W-1:0]  cfg_wr_data
);
    import stfr_pkg::*;

    logic [TICKS_W-1:0] ticks_reg;
    item_t              item;
    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               out_valid_reg;
    result_t            out_res_reg;

    always_comb
    begin
        item.mode       = s_tuser;
        item.rx_byte    = s_tdata[7:0];
        item.read_index = s_tdata[8 +: ADDR_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= SILENCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            ticks_reg <= cfg_wr_data;
        end
    end

    stfr_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_item       (item),
        .silence_ticks (ticks_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - RESULT_W)'(0), out_res_reg};

endmodule

`default_nettype wire

[src/stfr_checker.sv]
`timescale 1ns / 1ps
`include "silence_timeout_frame_receiver_unit_assert.svh"
`default_nettype none

module stfr_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    input  wire logic [stfr_pkg::OUT_W-1:0] m_tdata
);
    import stfr_pkg::*;

    result_t r;

    assign r = m_tdata[RESULT_W-1:0];

    `STFR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `STFR_ASSERT_NOW(a_count_range, m_tvalid, r.byte_count <= CNT_W'(BUF_DEPTH), "byte count above buffer depth")
    `STFR_ASSERT_NOW(a_ready_needs_bytes, m_tvalid && r.frame_ready, r.byte_count != '0, "frame ready with empty buffer")
    `STFR_ASSERT_NOW(a_drop_when_full, m_tvalid && r.byte_dropped, (r.byte_count == CNT_W'(BUF_DEPTH)) && r.timer_running, "byte dropped while buffer not full")

endmodule

bind silence_timeout_frame_receiver_unit stfr_checker u_stfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import stfr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    class frame_scoreboard;
        logic [7:0]    store [BUF_DEPTH];
        int unsigned   held;
        int unsigned   silence;
        bit            counting;
        bit            ready;
        logic [15:0]   ticks;
        result_t       expected_q [$];
        int unsigned   errors;

        function new();
            held     = 0;
            silence  = 0;
            counting = 1'b0;
            ready    = 1'b0;
            ticks    = SILENCE_RESET;
            errors   = 0;
        endfunction

        function void note_input(item_t it);
            result_t r;
            r = '0;
            case (it.mode)
                MODE_BYTE:
                begin
                    if (held < BUF_DEPTH)
                    begin
                        store[held] = it.rx_byte;
                        held++;
                    end
                    else
                    begin
                        r.byte_dropped = 1'b1;
                    end
                    silence  = 0;
                    counting = 1'b1;
                end
                MODE_TICK:
                begin
                    if (counting)
                    begin
                        silence = (silence + 1) & 32'hFFFF;
                        if (silence >= ticks)
                        begin
                            counting = 1'b0;
                            if (held > 0)
                                ready = 1'b1;
                        end
                    end
                end
                MODE_READ:
                begin
                    if (it.read_index < held)
                        r.read_data = store[it.read_index];
                end
                default:
                begin
                    if (held > 0)
                        r.read_data = store[0];
                    held  = 0;
                    ready = 1'b0;
                end
            endcase
            r.frame_ready   = ready;
            r.byte_count    = CNT_W'(held);
            r.timer_running = counting;
            expected_q.push_back(r);
        endfunction

        function void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
            $error("%s: expected %0h, actual %0h", field, want, got);
            errors++;
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            result_t got;
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            got  = result_t'(data[RESULT_W-1:0]);
            if (got.frame_ready !== want.frame_ready)
                report_mismatch("frame_ready", want.frame_ready, got.frame_ready);
            if (got.byte_count !== want.byte_count)
                report_mismatch("byte_count", want.byte_count, got.byte_count);
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", want.read_data, got.read_data);
            if (got.timer_running !== want.timer_running)
                report_mismatch("timer_running", want.timer_running, got.timer_running);
            if (got.byte_dropped !== want.byte_dropped)
                report_mismatch("byte_dropped", want.byte_dropped, got.byte_dropped);
            if (data[OUT_W-1:RESULT_W] !== '0)
                report_mismatch("pad", 0, data[OUT_W-1:RESULT_W]);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_wr_en;
    logic [TICKS_W-1:0]  cfg_wr_data;

    frame_scoreboard sb = new();

    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned cycle_count;
    int unsigned stall_left;
    int unsigned stall_kind;
    logic [7:0]  stall_pattern;
    logic [2:0]  stall_phase;

    silence_timeout_frame_receiver_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        m_tready      <= 1'b0;
        stall_left    = 0;
        stall_kind    = 0;
        stall_pattern = 8'hFF;
        stall_phase   = '0;
    end

    // The receiver switches between always ready, random stalls and a
    // repeating stall pattern.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_kind    = $urandom_range(0, 2);
            stall_left    = $urandom_range(32, 400);
            stall_pattern = 8'($urandom_range(0, 255)) | 8'h55;
        end
        stall_left--;
        stall_phase++;
        case (stall_kind)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= stall_pattern[stall_phase];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL silence_timeout_frame_receiver_unit");
        $finish;
    end

    task automatic send_item(input logic [1:0] mode, input logic [7:0] rx,
                             input logic [ADDR_W-1:0] idx);
        item_t it;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        it.mode       = mode;
        it.rx_byte    = rx;
        it.read_index = idx;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, idx, rx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(it);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_silence_ticks(input logic [TICKS_W-1:0] value);
        wait_until_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.ticks = value;
    endtask

    // A frame is a run of bytes with some noise, a run of ticks that usually
    // reaches a timeout of 40 or less, a few reads and usually a release.
    task automatic run_frame();
        int unsigned n_bytes;
        int unsigned n_ticks;
        int unsigned n_reads;
        logic [ADDR_W-1:0] idx;
        if ($urandom_range(0, 5) == 0)
            n_bytes = $urandom_range(60, 72);
        else
            n_bytes = $urandom_range(0, 30);
        for (int i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          6'($urandom_range(0, 63)));
            else
                send_item(MODE_BYTE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        end
        if (sb.ticks > 40)
            n_ticks = $urandom_range(0, 40);
        else if ($urandom_range(0, 4) == 0)
            n_ticks = $urandom_range(0, sb.ticks);
        else
            n_ticks = sb.ticks + $urandom_range(0, 3);
        repeat (n_ticks)
            send_item(MODE_TICK, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        n_reads = $urandom_range(0, 5);
        repeat (n_reads)
        begin
            if (sb.held > 0 && $urandom_range(0, 1) == 1)
                idx = 6'($urandom_range(0, sb.held - 1));
            else
                idx = 6'($urandom_range(0, 63));
            send_item(MODE_READ, 8'($urandom_range(0, 255)), idx);
        end
        if ($urandom_range(0, 4) != 0)
            send_item(MODE_RELEASE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        if ($urandom_range(0, 11) == 0)
            wait_until_idle();
    endtask

    initial
    begin
        logic [TICKS_W-1:0] phase_ticks [6];
        int unsigned target;
        items_sent  = 0;
        burst_left  = 0;
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= MODE_BYTE;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset value of the timeout: empty buffer, stopped timer, reads.
        send_item(MODE_RELEASE, 8'h00, 6'd0);
        send_item(MODE_READ, 8'h00, 6'd0);
        send_item(MODE_TICK, 8'h00, 6'd0);
        send_item(MODE_BYTE, 8'h00, 6'd0);
        send_item(MODE_BYTE, 8'hFF, 6'd63);
        send_item(MODE_BYTE, 8'hA5, 6'd0);
        send_item(MODE_READ, 8'hFF, 6'd0);
        send_item(MODE_READ, 8'h00, 6'd1);
        send_item(MODE_READ, 8'h00, 6'd2);
        send_item(MODE_READ, 8'h00, 6'd3);
        send_item(MODE_READ, 8'h00, 6'd63);
        send_item(MODE_TICK, 8'h00, 6'd0);
        send_item(MODE_RELEASE, 8'h00, 6'd0);
        send_item(MODE_TICK, 8'h00, 6'd0);

        // Timeout on an empty buffer, ready, a byte after ready, release.
        set_silence_ticks(16'd1);
        send_item(MODE_TICK, 8'h00, 6'd0);
        send_item(MODE_BYTE, 8'h5A, 6'd0);
        send_item(MODE_TICK, 8'h00, 6'd0);
        send_item(MODE_BYTE, 8'h3C, 6'd0);
        send_item(MODE_READ, 8'h00, 6'd1);
        send_item(MODE_TICK, 8'h00, 6'd0);
        send_item(MODE_RELEASE, 8'h00, 6'd0);

        phase_ticks[0] = 16'd0;
        phase_ticks[1] = 16'd2;
        phase_ticks[2] = 16'd7;
        phase_ticks[3] = 16'($urandom_range(3, 30));
        phase_ticks[4] = 16'hFFFF;
        phase_ticks[5] = 16'($urandom_range(1, 12));
        for (int p = 0; p < 6; p++)
        begin
            set_silence_ticks(phase_ticks[p]);
            target = items_sent + 300;
            while (items_sent < target)
                run_frame();
        end

        wait_until_idle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS silence_timeout_frame_receiver_unit");
        else
            $display("FAIL silence_timeout_frame_receiver_unit");
        $finish;
    end

endmodule
